// ===== rtl/ile_pkg.sv =====
// ---------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Command and status codes, word layouts and the control word that is
// broadcast to every storage cell of the list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

  // list geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the command and result words
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FPOS_W  = 6;
  localparam int unsigned COUNT_W = 7;

  // width used to compare a position against the count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_SET    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // operation applied by every cell in the execute cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_WRITE,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] data_out;
    logic [FPOS_W-1:0]       found_position;
    logic [COUNT_W-1:0]      count;
    logic                    is_empty;
  } rsp_t;

  // broadcast control word for the cell row
  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ile_cell.sv =====
// ---------------------------------------------------------------------------
// ile_cell: one storage cell of the list
// Holds one entry, takes a new value or a neighbor's entry on a shift,
// registers an equality match for search and drives its entry onto the
// read bus when selected.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_cell (
  input  wire logic                       clk_i,
  input  wire logic [ile_pkg::IDX_W-1:0]  idx_i,
  input  wire ile_pkg::cell_ctl_t         ctl_i,
  input  wire logic [ile_pkg::DATA_W-1:0] left_i,
  input  wire logic [ile_pkg::DATA_W-1:0] right_i,
  input  wire logic                       cmp_en_i,
  input  wire logic [ile_pkg::DATA_W-1:0] cmp_val_i,
  output logic [ile_pkg::DATA_W-1:0]      entry_o,
  output logic [ile_pkg::DATA_W-1:0]      rd_o,
  output logic                            match_o
);

  logic [ile_pkg::DATA_W-1:0] entry_q, entry_d;
  logic                       match_q;
  logic                       at_pos, above_pos;

  assign at_pos    = (idx_i == ctl_i.pos);
  assign above_pos = (idx_i > ctl_i.pos);

  // next entry per broadcast op
  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      ile_pkg::OP_WRITE: begin
        if (at_pos) entry_d = ctl_i.value;
      end
      ile_pkg::OP_SHIFT_UP: begin
        if (above_pos) entry_d = left_i;
        else if (at_pos) entry_d = ctl_i.value;
      end
      ile_pkg::OP_SHIFT_DOWN: begin
        if (above_pos || at_pos) entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // search compare, taken when the command word is accepted
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) match_q <= (entry_q == cmp_val_i);
  end

  assign entry_o = entry_q;
  assign rd_o    = at_pos ? entry_q : '0;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_engine.sv =====
// ---------------------------------------------------------------------------
// indexed_list_engine: bounded ordered list of signed values
// Command engine over a row of storage cells: append, insert, set, remove,
// get, find and clear, one result word per command.
// ---------------------------------------------------------------------------
// Start is taken when busy is low, busy is high for the following
// execute cycle, and the result word appears with a one-cycle done_o
// strobe right after it, when busy is already low again, so a new
// command can be taken in the cycle the result appears. The receiver cannot
// stall; it must capture the result in the cycle done_o is high. All cells
// compare against the searched value at acceptance and shift in parallel
// in the execute cycle, so the latency does not depend on list length.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire ile_pkg::req_t req_i,
  output logic               busy,
  output logic               done_o,
  output ile_pkg::rsp_t      rsp_o
);

  localparam int unsigned N   = ile_pkg::CAPACITY;
  localparam int unsigned DW  = ile_pkg::DATA_W;
  localparam int unsigned IW  = ile_pkg::IDX_W;
  localparam int unsigned CW  = ile_pkg::CNT_W;
  localparam int unsigned MW  = ile_pkg::CMP_W;

  ile_pkg::state_e   state_q, state_d;
  ile_pkg::req_t     req_q;
  ile_pkg::rsp_t     rsp_q, rsp_d;
  logic              done_q, done_d;
  logic [CW-1:0]     count_q, count_d;
  logic              accept;
  logic              exec;

  ile_pkg::cell_ctl_t ctl;
  logic [DW-1:0]      entry_w [N];
  logic [DW-1:0]      rd_w    [N];
  logic [N-1:0]       match_w;
  logic [DW-1:0]      cmp_val;

  assign accept  = start && !busy;
  assign exec    = (state_q == ile_pkg::ST_EXEC);
  assign cmp_val = DW'(unsigned'(req_i.item_value));

  // ---- sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ile_pkg::ST_IDLE: begin
        if (start) state_d = ile_pkg::ST_EXEC;
      end
      ile_pkg::ST_EXEC: begin
        state_d = ile_pkg::ST_IDLE;
      end
      default: begin
        state_d = ile_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- sequencer: outputs
  always_comb begin
    case (state_q)
      ile_pkg::ST_EXEC: busy = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ile_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // command word capture
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
  end

  // ---- cell row
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end

    ile_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (IW'(g)),
      .ctl_i     (ctl),
      .left_i    (left_w),
      .right_i   (right_w),
      .cmp_en_i  (accept),
      .cmp_val_i (cmp_val),
      .entry_o   (entry_w[g]),
      .rd_o      (rd_w[g]),
      .match_o   (match_w[g])
    );
  end

  // ---- read bus and first-match search
  logic [DW-1:0] rd_data;
  logic [N-1:0]  valid_m, hit_m, first_m;
  logic [IW-1:0] hit_idx;

  always_comb begin
    rd_data = '0;
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      valid_m[i] = (CW'(i) < count_q);
      rd_data    = rd_data | rd_w[i];
    end
    hit_m   = match_w & valid_m;
    first_m = hit_m & (~hit_m + N'(1));  // isolate lowest set bit
    for (int i = 0; i < N; i++) begin
      if (first_m[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  // ---- execute: decode, range checks, result word
  logic [MW-1:0] pos_x, cnt_x;
  logic          full;

  assign pos_x = MW'(req_q.position);
  assign cnt_x = MW'(count_q);
  assign full  = (count_q == CW'(N));

  always_comb begin
    ctl.op    = ile_pkg::OP_HOLD;
    ctl.pos   = IW'(req_q.position);
    ctl.value = DW'(unsigned'(req_q.item_value));
    count_d   = count_q;
    done_d    = exec;
    rsp_d     = rsp_q;
    if (exec) begin
      rsp_d.status         = ile_pkg::STAT_OK;
      rsp_d.data_out       = '0;
      rsp_d.found_position = '0;
      case (req_q.cmd)
        ile_pkg::CMD_APPEND: begin
          if (full) begin
            rsp_d.status = ile_pkg::STAT_FULL;
          end else begin
            ctl.op  = ile_pkg::OP_WRITE;
            ctl.pos = IW'(count_q);
            count_d = count_q + CW'(1);
          end
        end
        ile_pkg::CMD_INSERT: begin
          if (pos_x > cnt_x) begin
            rsp_d.status = ile_pkg::STAT_RANGE;
          end else if (full) begin
            rsp_d.status = ile_pkg::STAT_FULL;
          end else begin
            ctl.op  = ile_pkg::OP_SHIFT_UP;
            count_d = count_q + CW'(1);
          end
        end
        ile_pkg::CMD_SET: begin
          if (pos_x >= cnt_x) rsp_d.status = ile_pkg::STAT_RANGE;
          else ctl.op = ile_pkg::OP_WRITE;
        end
        ile_pkg::CMD_REMOVE: begin
          if (pos_x >= cnt_x) begin
            rsp_d.status = ile_pkg::STAT_RANGE;
          end else begin
            ctl.op         = ile_pkg::OP_SHIFT_DOWN;
            rsp_d.data_out = signed'(ile_pkg::VAL_W'(rd_data));
            count_d        = count_q - CW'(1);
          end
        end
        ile_pkg::CMD_GET: begin
          if (pos_x >= cnt_x) rsp_d.status = ile_pkg::STAT_RANGE;
          else rsp_d.data_out = signed'(ile_pkg::VAL_W'(rd_data));
        end
        ile_pkg::CMD_FIND: begin
          if (|hit_m) rsp_d.found_position = ile_pkg::FPOS_W'(hit_idx);
          else rsp_d.status = ile_pkg::STAT_NOT_FOUND;
        end
        ile_pkg::CMD_CLEAR: begin
          count_d = '0;
        end
        default: begin
          // unused code: no change
        end
      endcase
      rsp_d.count    = ile_pkg::COUNT_W'(count_d);
      rsp_d.is_empty = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // ---- assertions
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(N))
    else $error("entry count above capacity");

  a_done_after_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> done_o)
    else $error("execute cycle without result strobe");

  a_busy_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.is_empty == (rsp_o.count == '0)))
    else $error("empty flag disagrees with count");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (req_q.cmd != ile_pkg::CMD_CLEAR) |=>
      (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
      (count_q == $past(count_q) - CW'(1)))
    else $error("count moved by more than one");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the indexed list engine
// Drives list commands through the start/busy handshake with random gaps.
// A shadow copy of the list predicts each result word, and every done_o
// strobe is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // encoding outside the command set, must be ignored by the engine
  localparam logic [ile_pkg::CMD_W-1:0] CMD_UNDEF = 3'd7;
  localparam int unsigned NUM_WORDS = 1950;
  localparam logic [ile_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [ile_pkg::VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  // shadow list and queue of expected result words
  class list_scoreboard;
    logic signed [ile_pkg::VAL_W-1:0] entries [ile_pkg::CAPACITY];
    int unsigned count;
    ile_pkg::rsp_t awaited_results[$];
    int unsigned errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // apply an accepted command to the shadow list, queue its result word
    function void note_command(ile_pkg::req_t r);
      ile_pkg::rsp_t want;
      int unsigned p;
      int unsigned i;
      p    = r.position;
      want = '0;
      want.status = ile_pkg::STAT_OK;
      case (r.cmd)
        ile_pkg::CMD_APPEND: begin
          if (count >= ile_pkg::CAPACITY) begin
            want.status = ile_pkg::STAT_FULL;
          end else begin
            entries[count] = r.item_value;
            count++;
          end
        end
        ile_pkg::CMD_INSERT: begin
          // range check wins over the full check
          if (p > count) begin
            want.status = ile_pkg::STAT_RANGE;
          end else if (count >= ile_pkg::CAPACITY) begin
            want.status = ile_pkg::STAT_FULL;
          end else begin
            for (i = count; i > p; i--) entries[i] = entries[i-1];
            entries[p] = r.item_value;
            count++;
          end
        end
        ile_pkg::CMD_SET: begin
          if (p >= count) want.status = ile_pkg::STAT_RANGE;
          else entries[p] = r.item_value;
        end
        ile_pkg::CMD_REMOVE: begin
          if (p >= count) begin
            want.status = ile_pkg::STAT_RANGE;
          end else begin
            want.data_out = entries[p];
            for (i = p; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
          end
        end
        ile_pkg::CMD_GET: begin
          if (p >= count) want.status = ile_pkg::STAT_RANGE;
          else want.data_out = entries[p];
        end
        ile_pkg::CMD_FIND: begin
          want.status = ile_pkg::STAT_NOT_FOUND;
          for (i = 0; i < count; i++) begin
            if (entries[i] == r.item_value) begin
              want.status         = ile_pkg::STAT_OK;
              want.found_position = ile_pkg::FPOS_W'(i);
              break;
            end
          end
        end
        ile_pkg::CMD_CLEAR: count = 0;
        default: ;
      endcase
      want.count    = ile_pkg::COUNT_W'(count);
      want.is_empty = (count == 0);
      awaited_results = {awaited_results, want};
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(ile_pkg::rsp_t got);
      ile_pkg::rsp_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.data_out !== want.data_out) report("data_out", want.data_out, got.data_out);
      if (got.found_position !== want.found_position)
        report("found_position", want.found_position, got.found_position);
      if (got.count !== want.count) report("count", want.count, got.count);
      if (got.is_empty !== want.is_empty) report("is_empty", want.is_empty, got.is_empty);
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  ile_pkg::req_t  req_i;
  logic           busy;
  logic           done_o;
  ile_pkg::rsp_t  rsp_o;

  list_scoreboard sb;
  int unsigned issued;
  bit no_gaps;

  indexed_list_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // results cannot be held off, so take every strobe
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) sb.check_result(rsp_o);
  end

  // send one command word, optionally after an idle gap
  task automatic issue(ile_pkg::cmd_e c, int unsigned pos,
                       logic [ile_pkg::VAL_W-1:0] v);
    ile_pkg::req_t r;
    int unsigned gap;
    r.cmd        = c;
    r.position   = ile_pkg::POS_W'(pos);
    r.item_value = v;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(r);
    issued++;
  endtask

  // values lean on a small pool and on stored entries so finds hit
  function automatic logic [ile_pkg::VAL_W-1:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return ile_pkg::VAL_W'($signed($urandom_range(0, 8)) - 4);
    if (sel == 4) return ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
    if (sel < 7 && sb.count != 0) return sb.entries[$urandom_range(0, sb.count - 1)];
    return $urandom();
  endfunction

  // mostly near the live range, sometimes anywhere in the field
  function automatic int unsigned rand_pos();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 127);
    return $urandom_range(0, sb.count);
  endfunction

  function automatic ile_pkg::cmd_e rand_cmd();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 15) return ile_pkg::CMD_APPEND;
    if (w < 30) return ile_pkg::CMD_INSERT;
    if (w < 42) return ile_pkg::CMD_SET;
    if (w < 57) return ile_pkg::CMD_REMOVE;
    if (w < 72) return ile_pkg::CMD_GET;
    if (w < 96) return ile_pkg::CMD_FIND;
    if (w < 98) return ile_pkg::CMD_CLEAR;
    return ile_pkg::cmd_e'(CMD_UNDEF);
  endfunction

  initial begin
    int unsigned sel;
    int unsigned target;
    int unsigned wait_cycles;
    sb      = new();
    issued  = 0;
    no_gaps = 1'b0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, extremes, boundaries, undefined command
    issue(ile_pkg::CMD_GET, 0, 32'd0);
    issue(ile_pkg::CMD_REMOVE, 0, 32'd0);
    issue(ile_pkg::CMD_FIND, 0, 32'd0);
    issue(ile_pkg::CMD_SET, 0, 32'd1);
    issue(ile_pkg::CMD_APPEND, 0, VAL_MIN);
    issue(ile_pkg::CMD_APPEND, 0, VAL_MAX);
    issue(ile_pkg::CMD_APPEND, 0, 32'd0);
    issue(ile_pkg::CMD_APPEND, 0, 32'hffff_ffff);
    issue(ile_pkg::CMD_INSERT, 0, 32'd5);
    issue(ile_pkg::CMD_INSERT, 5, 32'd7);
    issue(ile_pkg::CMD_INSERT, 7, 32'd9);
    issue(ile_pkg::CMD_INSERT, 127, 32'd9);
    issue(ile_pkg::CMD_GET, 0, 32'd0);
    issue(ile_pkg::CMD_GET, 5, 32'd0);
    issue(ile_pkg::CMD_GET, 6, 32'd0);
    issue(ile_pkg::CMD_SET, 2, 32'h5555_aaaa);
    issue(ile_pkg::CMD_SET, 127, 32'h1);
    issue(ile_pkg::CMD_FIND, 0, VAL_MAX);
    issue(ile_pkg::CMD_FIND, 0, 32'd12345);
    issue(ile_pkg::CMD_REMOVE, 0, 32'd0);
    issue(ile_pkg::CMD_REMOVE, 4, 32'd0);
    issue(ile_pkg::CMD_REMOVE, 127, 32'd0);
    issue(ile_pkg::cmd_e'(CMD_UNDEF), 3, 32'hdead_beef);
    issue(ile_pkg::CMD_CLEAR, 0, 32'd0);
    issue(ile_pkg::CMD_GET, 0, 32'd0);

    // random episodes: fill to capacity, drain, or mixed traffic
    while (issued < NUM_WORDS) begin
      sel     = $urandom_range(0, 9);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (sel < 2) begin
        while (sb.count < ile_pkg::CAPACITY) begin
          if ($urandom_range(0, 1) != 0)
            issue(ile_pkg::CMD_APPEND, rand_pos(), rand_value());
          else
            issue(ile_pkg::CMD_INSERT, $urandom_range(0, sb.count), rand_value());
        end
        // full list: append, insert in range, insert out of range
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) != 0)
            issue(ile_pkg::CMD_APPEND, rand_pos(), rand_value());
          else
            issue(ile_pkg::CMD_INSERT, $urandom_range(0, 127), rand_value());
        end
      end else if (sel == 2) begin
        target = $urandom_range(0, 8);
        while (sb.count > target)
          issue(ile_pkg::CMD_REMOVE, $urandom_range(0, sb.count - 1), rand_value());
      end else begin
        repeat ($urandom_range(20, 60)) issue(rand_cmd(), rand_pos(), rand_value());
      end
    end
    start <= 1'b0;

    // drain outstanding results, then a short settle
    wait_cycles = 0;
    while (sb.awaited_results.size() != 0 && wait_cycles < 100) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (sb.awaited_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, sb.awaited_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/indexed_list_engine.sv
dv/testbench.sv
